### src/nns_pkg.sv
`default_nettype none

package nns_pkg;

    // Field widths
    localparam int unsigned PIX_W    = 32;
    localparam int unsigned DIM_W    = 16;
    localparam int unsigned SCL_W    = 16;
    localparam int unsigned SIZE_W   = 8;
    localparam int unsigned LCNT_W   = 15;
    localparam int unsigned FRAC_W   = 8;

    // Parameter defaults
    localparam int unsigned MAX_WIDTH_DEF  = 128;
    localparam int unsigned MAX_HEIGHT_DEF = 128;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [SIZE_W-1:0] SRC_SIZE_RESET = 8'd128;

    typedef enum logic {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_SCALE = 2'd1,
        REQ_FETCH = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Input word
    typedef struct packed {
        logic [1:0]       req_type;
        logic [PIX_W-1:0] load_pixel;
        logic [SCL_W-1:0] x_scale;
        logic [SCL_W-1:0] y_scale;
        logic             relative;
        logic [DIM_W-1:0] out_column;
        logic [DIM_W-1:0] out_row;
    } t_in;

    // Result word
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [DIM_W-1:0] scaled_width;
        logic [DIM_W-1:0] scaled_height;
        logic [1:0]       status;
    } t_out;

    // Serial unit operations: scale is a 16-step multiply, map is an
    // 8-step multiply followed by an 8-step divide
    typedef enum logic {
        SU_SCALE = 1'b0,
        SU_MAP   = 1'b1
    } t_su_op;

    typedef struct packed {
        logic   start;
        t_su_op op;
    } t_su_ctrl;

endpackage

`default_nettype wire

### src/nns_ram.sv
`default_nettype none

module nns_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16384,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/nns_serial_unit.sv
`default_nettype none

module nns_serial_unit
    import nns_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_su_ctrl         i_ctrl,
    input  wire logic [DIM_W-1:0] i_multiplicand,
    input  wire logic [SCL_W-1:0] i_multiplier,
    input  wire logic [DIM_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [2*DIM_W-1:0]    o_result
);

    localparam int unsigned ACC_W = 2 * DIM_W;
    localparam int unsigned CNT_W = $clog2(SCL_W + 1);
    localparam int unsigned QW    = SIZE_W;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } t_ustate;

    t_ustate            r_state;
    t_su_op             r_op;
    logic               r_done;
    logic [ACC_W-1:0]   r_acc;
    logic [SCL_W-1:0]   r_mplr;
    logic [DIM_W-1:0]   r_mcand;
    logic [DIM_W-1:0]   r_dvsr;
    logic [CNT_W-1:0]   r_cnt;

    logic [ACC_W-1:0]   n_mul_acc;
    logic [DIM_W:0]     n_trial;
    logic [DIM_W:0]     n_diff;
    logic               n_qbit;
    logic [DIM_W-1:0]   n_rem;
    logic [ACC_W-1:0]   n_div_acc;

    // Multiply step: shift the partial product, add the multiplicand on a one bit
    // of the multiplier, MSB first
    always_comb begin
        n_mul_acc = {r_acc[ACC_W-2:0], 1'b0}
                  + (r_mplr[SCL_W-1] ? {{(ACC_W-DIM_W){1'b0}}, r_mcand} : '0);
    end

    // Restoring divide step: remainder sits above the quotient bits,
    // quotient bits shift in at the bottom
    always_comb begin
        n_trial   = {r_acc[QW+DIM_W-1:QW], r_acc[QW-1]};
        n_diff    = n_trial - {1'b0, r_dvsr};
        n_qbit    = (n_trial >= {1'b0, r_dvsr});
        n_rem     = n_qbit ? n_diff[DIM_W-1:0] : n_trial[DIM_W-1:0];
        n_div_acc = {{(ACC_W-DIM_W-QW){1'b0}}, n_rem, r_acc[QW-2:0], n_qbit};
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                U_IDLE: begin
                    if (i_ctrl.start) begin
                        r_op    <= i_ctrl.op;
                        r_acc   <= '0;
                        r_mplr  <= i_multiplier;
                        r_mcand <= i_multiplicand;
                        r_dvsr  <= i_divisor;
                        r_cnt   <= (i_ctrl.op == SU_SCALE) ? CNT_W'(SCL_W) : CNT_W'(QW);
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_acc  <= n_mul_acc;
                    r_mplr <= {r_mplr[SCL_W-2:0], 1'b0};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        if (r_op == SU_MAP) begin
                            r_cnt   <= CNT_W'(QW);
                            r_state <= U_DIV;
                        end else begin
                            r_done  <= 1'b1;
                            r_state <= U_IDLE;
                        end
                    end
                end
                U_DIV: begin
                    r_acc <= n_div_acc;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

### src/nearest_neighbour_image_scaler.sv
`default_nettype none

// Nearest-neighbor image scaler. Load words fill the source image in raster
// order; the scaled size takes the source size once the last pixel lands, and
// loads past the end report overflow. Scale words set the scaled size from U8.8
// factors, fetch words return the source pixel under a scaled column and row.
// One word is in flight at a time; the result sits in an output register, so a
// new word is taken while the previous result waits. A scale word runs a
// 16-step bit-serial multiply, an in-range fetch word an 8-step multiply and
// 8-step restoring divide per axis, both axes in parallel, then address and RAM
// read; load, no-op and out-of-range fetch words skip the serial units. Writing
// either size register restarts loading; the stored pixels and the scaled size
// are kept.
module nearest_neighbour_image_scaler
    import nns_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire t_in                   i_in_data,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out                       o_out_data,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned WCAP  = (MAX_WIDTH  > 255) ? 255 : MAX_WIDTH;
    localparam int unsigned HCAP  = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
    localparam logic [SIZE_W-1:0] W_CAP = WCAP[SIZE_W-1:0];
    localparam logic [SIZE_W-1:0] H_CAP = HCAP[SIZE_W-1:0];
    localparam int unsigned ACC_W = 2 * DIM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_READ,
        S_FINISH
    } t_state;

    t_state              r_state;
    t_su_op              r_op;
    logic                r_fetch_ok;
    t_status             r_status;
    logic                r_out_valid;
    t_out                r_out;
    logic [SIZE_W-1:0]   r_src_w;
    logic [SIZE_W-1:0]   r_src_h;
    logic [LCNT_W-1:0]   r_load_count;
    logic [DIM_W-1:0]    r_cur_w;
    logic [DIM_W-1:0]    r_cur_h;
    logic [AW-1:0]       r_addr;

    logic                in_accept;
    logic                cfg_write;
    logic [SIZE_W-1:0]   eff_w;
    logic [SIZE_W-1:0]   eff_h;
    logic [2*SIZE_W-1:0] total;
    logic                load_room;
    logic [LCNT_W-1:0]   n_load_count;
    logic                in_range;
    logic [DIM_W-1:0]    base_w;
    logic [DIM_W-1:0]    base_h;
    t_su_ctrl            su_ctrl;
    logic [DIM_W-1:0]    x_mcand;
    logic [DIM_W-1:0]    y_mcand;
    logic [SCL_W-1:0]    x_mplr;
    logic [SCL_W-1:0]    y_mplr;
    logic                x_done;
    logic                y_done;
    logic [ACC_W-1:0]    x_result;
    logic [ACC_W-1:0]    y_result;
    logic [DIM_W-1:0]    n_cur_w;
    logic [DIM_W-1:0]    n_cur_h;
    logic [SIZE_W-1:0]   src_col;
    logic [SIZE_W-1:0]   src_row;
    logic [2*SIZE_W:0]   n_addr_full;
    logic [AW-1:0]       n_addr;
    logic                ram_wr_en;
    logic [PIX_W-1:0]    ram_rd_data;

    assign in_accept = i_valid && o_ready;
    assign cfg_write = psel && penable && pwrite;

    // Effective source size: zero reads as one, saturate at the maximum
    always_comb begin
        eff_w = (r_src_w == '0) ? SIZE_W'(1) : ((r_src_w > W_CAP) ? W_CAP : r_src_w);
        eff_h = (r_src_h == '0) ? SIZE_W'(1) : ((r_src_h > H_CAP) ? H_CAP : r_src_h);
        total = (2*SIZE_W)'(eff_w) * (2*SIZE_W)'(eff_h);
    end

    assign load_room    = ({1'b0, r_load_count} < total);
    assign n_load_count = r_load_count + 1'b1;
    assign in_range     = (i_in_data.out_column < r_cur_w) && (i_in_data.out_row < r_cur_h);
    assign ram_wr_en    = in_accept && (i_in_data.req_type == REQ_LOAD) && load_room;

    // Start the serial units for scale words and in-range fetch words
    always_comb begin
        base_w        = i_in_data.relative ? r_cur_w : {{(DIM_W-SIZE_W){1'b0}}, eff_w};
        base_h        = i_in_data.relative ? r_cur_h : {{(DIM_W-SIZE_W){1'b0}}, eff_h};
        su_ctrl.start = in_accept && ((i_in_data.req_type == REQ_SCALE)
                      || ((i_in_data.req_type == REQ_FETCH) && in_range));
        su_ctrl.op    = (i_in_data.req_type == REQ_SCALE) ? SU_SCALE : SU_MAP;
        if (su_ctrl.op == SU_SCALE) begin
            x_mcand = base_w;
            y_mcand = base_h;
            x_mplr  = i_in_data.x_scale;
            y_mplr  = i_in_data.y_scale;
        end else begin
            x_mcand = i_in_data.out_column;
            y_mcand = i_in_data.out_row;
            x_mplr  = {eff_w, {(SCL_W-SIZE_W){1'b0}}};
            y_mplr  = {eff_h, {(SCL_W-SIZE_W){1'b0}}};
        end
    end

    nns_serial_unit u_x_unit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (su_ctrl),
        .i_multiplicand (x_mcand),
        .i_multiplier   (x_mplr),
        .i_divisor      (r_cur_w),
        .o_done         (x_done),
        .o_result       (x_result)
    );

    nns_serial_unit u_y_unit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (su_ctrl),
        .i_multiplicand (y_mcand),
        .i_multiplier   (y_mplr),
        .i_divisor      (r_cur_h),
        .o_done         (y_done),
        .o_result       (y_result)
    );

    // Drop the fraction of the scaled size and saturate
    always_comb begin
        n_cur_w = (x_result[ACC_W-1:DIM_W+FRAC_W] != '0) ? '1
                : x_result[DIM_W+FRAC_W-1:FRAC_W];
        n_cur_h = (y_result[ACC_W-1:DIM_W+FRAC_W] != '0) ? '1
                : y_result[DIM_W+FRAC_W-1:FRAC_W];
    end

    // Clamp the source column and row, form the raster address
    always_comb begin
        src_col     = (x_result[SIZE_W-1:0] > eff_w - 1'b1) ? eff_w - 1'b1
                    : x_result[SIZE_W-1:0];
        src_row     = (y_result[SIZE_W-1:0] > eff_h - 1'b1) ? eff_h - 1'b1
                    : y_result[SIZE_W-1:0];
        n_addr_full = (2*SIZE_W+1)'(src_row) * (2*SIZE_W+1)'(eff_w)
                    + (2*SIZE_W+1)'(src_col);
        n_addr      = AW'(n_addr_full);
    end

    nns_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (AW'(r_load_count)),
        .i_wr_data (i_in_data.load_pixel),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_rd_data)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SRC_SIZE_RESET;
            r_src_h <= SRC_SIZE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_SRC_HEIGHT) begin
                r_src_h <= pwdata[SIZE_W-1:0];
            end else begin
                r_src_w <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SRC_HEIGHT) ? APB_DATA_W'(r_src_h) : APB_DATA_W'(r_src_w);
    assign pready = 1'b1;

    // Sequence one word at a time, hold the result in the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_load_count <= '0;
            r_cur_w      <= '0;
            r_cur_h      <= '0;
            r_fetch_ok   <= 1'b0;
            r_status     <= ST_OK;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write) begin
                r_load_count <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_fetch_ok <= 1'b0;
                        r_status   <= ST_OK;
                        r_op       <= su_ctrl.op;
                        case (i_in_data.req_type)
                            REQ_LOAD: begin
                                if (load_room) begin
                                    r_load_count <= n_load_count;
                                    if ({1'b0, n_load_count} == total) begin
                                        r_cur_w <= DIM_W'(eff_w);
                                        r_cur_h <= DIM_W'(eff_h);
                                    end
                                end else begin
                                    r_status <= ST_OVERFLOW;
                                end
                                r_state <= S_FINISH;
                            end
                            REQ_SCALE: begin
                                r_state <= S_CALC;
                            end
                            REQ_FETCH: begin
                                if (in_range) begin
                                    r_state <= S_CALC;
                                end else begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_FINISH;
                                end
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_CALC: begin
                    if (x_done) begin
                        if (r_op == SU_SCALE) begin
                            r_cur_w <= n_cur_w;
                            r_cur_h <= n_cur_h;
                            r_state <= S_FINISH;
                        end else begin
                            r_addr     <= n_addr;
                            r_fetch_ok <= 1'b1;
                            r_state    <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.pixel         <= r_fetch_ok ? ram_rd_data : '0;
                        r_out.scaled_width  <= r_cur_w;
                        r_out.scaled_height <= r_cur_h;
                        r_out.status        <= r_status;
                        r_out_valid         <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_out_data = r_out;

    // Both axes run the same number of steps and finish together
    a_units_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_done == y_done)
        else $error("serial units out of step");

    // A unit finishes only while the sequencer waits for it
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_done |-> r_state == S_CALC)
        else $error("serial unit finished outside calculation");

    // The fetch address stays inside the store
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ({1'b0, r_addr} < (AW+1)'(DEPTH)))
        else $error("fetch address beyond store");

    // A failed word carries a zero pixel
    a_zero_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out_data.status != ST_OK)) |-> (o_out_data.pixel == '0))
        else $error("nonzero pixel on error status");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Tracks the scaler's image store, load progress and scaled size, and keeps
// the result words still to come in arrival order.
class pixel_scoreboard;
    localparam int unsigned MAX_W = 128;
    localparam int unsigned MAX_H = 128;
    localparam int unsigned DEPTH = MAX_W * MAX_H;

    logic [31:0]     image_mem [DEPTH];
    bit              written [DEPTH];
    int unsigned     loaded;
    logic [15:0]     cur_w;
    logic [15:0]     cur_h;
    logic [7:0]      reg_w;
    logic [7:0]      reg_h;
    nns_pkg::t_out   awaited_words [$];
    int              errors;

    function new();
        loaded = 0;
        cur_w  = '0;
        cur_h  = '0;
        reg_w  = nns_pkg::SRC_SIZE_RESET;
        reg_h  = nns_pkg::SRC_SIZE_RESET;
        errors = 0;
        foreach (written[i]) written[i] = 1'b0;
    endfunction

    // Zero reads as one, anything past the store size saturates
    function int unsigned src_cols();
        if (reg_w == 0) return 1;
        return (reg_w > MAX_W) ? MAX_W : int'(reg_w);
    endfunction

    function int unsigned src_rows();
        if (reg_h == 0) return 1;
        return (reg_h > MAX_H) ? MAX_H : int'(reg_h);
    endfunction

    // Restart loading on any size write; image and scaled size stay
    function void write_reg(nns_pkg::t_reg_idx idx, logic [7:0] value);
        if (idx == nns_pkg::REG_SRC_WIDTH) begin
            reg_w = value;
        end else begin
            reg_h = value;
        end
        loaded = 0;
    endfunction

    function logic [15:0] scale_dim(logic [15:0] factor, logic [15:0] base);
        longint unsigned prod;
        prod = (longint'(factor) * longint'(base)) >> 8;
        return (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
    endfunction

    // Map a scaled column and row back to a store entry
    function int unsigned src_index(logic [15:0] col, logic [15:0] row);
        int unsigned sc;
        int unsigned sr;
        sc = (int'(col) * src_cols()) / int'(cur_w);
        sr = (int'(row) * src_rows()) / int'(cur_h);
        if (sc > src_cols() - 1) sc = src_cols() - 1;
        if (sr > src_rows() - 1) sr = src_rows() - 1;
        return sr * src_cols() + sc;
    endfunction

    function bit in_view(logic [15:0] col, logic [15:0] row);
        return (col < cur_w) && (row < cur_h);
    endfunction

    // A fetch is allowed unless it would land on an entry never loaded
    function bit fetch_safe(logic [15:0] col, logic [15:0] row);
        if (!in_view(col, row)) return 1'b1;
        return written[src_index(col, row)];
    endfunction

    function void predict_word(nns_pkg::t_in w);
        nns_pkg::t_out e;
        int unsigned   total;
        logic [15:0]   nw;
        logic [15:0]   nh;
        total    = src_cols() * src_rows();
        e.pixel  = '0;
        e.status = nns_pkg::ST_OK;
        case (nns_pkg::t_req'(w.req_type))
            nns_pkg::REQ_LOAD: begin
                if (loaded < total) begin
                    image_mem[loaded] = w.load_pixel;
                    written[loaded]   = 1'b1;
                    loaded++;
                    if (loaded == total) begin
                        cur_w = 16'(src_cols());
                        cur_h = 16'(src_rows());
                    end
                end else begin
                    e.status = nns_pkg::ST_OVERFLOW;
                end
            end
            nns_pkg::REQ_SCALE: begin
                nw = scale_dim(w.x_scale, w.relative ? cur_w : 16'(src_cols()));
                nh = scale_dim(w.y_scale, w.relative ? cur_h : 16'(src_rows()));
                cur_w = nw;
                cur_h = nh;
            end
            nns_pkg::REQ_FETCH: begin
                if (in_view(w.out_column, w.out_row)) begin
                    e.pixel = image_mem[src_index(w.out_column, w.out_row)];
                end else begin
                    e.status = nns_pkg::ST_RANGE;
                end
            end
            default: ;
        endcase
        e.scaled_width  = cur_w;
        e.scaled_height = cur_h;
        awaited_words = {awaited_words, e};
    endfunction

    function void check_word(nns_pkg::t_out got);
        nns_pkg::t_out e;
        if (awaited_words.size() == 0) begin
            $error("result word arrived with none awaited: %h", got);
            errors++;
            return;
        end
        e = awaited_words.pop_front();
        if (got.pixel !== e.pixel) begin
            $error("pixel: expected %h, got %h", e.pixel, got.pixel);
            errors++;
        end
        if (got.scaled_width !== e.scaled_width) begin
            $error("scaled_width: expected %0d, got %0d", e.scaled_width, got.scaled_width);
            errors++;
        end
        if (got.scaled_height !== e.scaled_height) begin
            $error("scaled_height: expected %0d, got %0d", e.scaled_height,
                   got.scaled_height);
            errors++;
        end
        if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            errors++;
        end
    endfunction
endclass

module testbench;
    import nns_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES  = 7;

    typedef enum {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    t_in                   i_in_data  = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    t_out                  o_out_data;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pixel_scoreboard sb;
    int              cycle_count = 0;
    int              burst_left  = 0;
    t_rx_mode        rx_mode     = RX_OPEN;
    int              rx_left     = 0;
    int              rx_phase    = 0;

    // Source sizes per phase, register values as written, then word counts
    int unsigned phase_w [NUM_PHASES] = '{4, 1, 0, 255, 2, 128, 9};
    int unsigned phase_h [NUM_PHASES] = '{3, 1, 0, 2, 255, 128, 7};
    int unsigned phase_n [NUM_PHASES] = '{150, 80, 60, 340, 350, 100, 150};

    nearest_neighbour_image_scaler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nearest_neighbour_image_scaler verification failed");
            $finish;
        end
    end

    // Check every result word taken from the block
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready) begin
            sb.check_word(o_out_data);
        end
    end

    // Stall the result side, switching among random stall patterns
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:  i_ready = 1'b1;
            RX_LIGHT: i_ready = ($urandom_range(0, 9) < 7);
            RX_HEAVY: i_ready = ($urandom_range(0, 9) < 3);
            default:  i_ready = (rx_phase % 5 == 0);
        endcase
    end

    // Hold the word until taken, then record it; returns at a falling edge
    task automatic send_word(input t_in w);
        i_in_data = w;
        i_valid   = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.predict_word(w);
        @(negedge i_clk);
    endtask

    // Send in bursts, mostly with idle gaps between them
    task automatic send_paced(input t_in w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        send_word(w);
        burst_left--;
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (sb.awaited_words.size() != 0) @(negedge i_clk);
    endtask

    // Write one size register, then read it back
    task automatic write_size(input t_reg_idx idx, input logic [7:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = {24'h0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        @(negedge i_clk);
        pwrite  = 1'b0;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== {24'h0, value}) begin
            $error("source size register %0d: expected %h, got %h", idx, value, prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_source(input logic [7:0] w, input logic [7:0] h);
        wait_drained();
        if ($urandom_range(0, 1)) begin
            write_size(REG_SRC_WIDTH, w);
            write_size(REG_SRC_HEIGHT, h);
        end else begin
            write_size(REG_SRC_HEIGHT, h);
            write_size(REG_SRC_WIDTH, w);
        end
    endtask

    function automatic t_in make_req(t_req r, logic [31:0] pix, logic [15:0] xs,
                                     logic [15:0] ys, logic rel, logic [15:0] col,
                                     logic [15:0] row);
        t_in w;
        w.req_type   = r;
        w.load_pixel = pix;
        w.x_scale    = xs;
        w.y_scale    = ys;
        w.relative   = rel;
        w.out_column = col;
        w.out_row    = row;
        return w;
    endfunction

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            4, 5:    return 16'h0100;
            default: return 16'($urandom_range(16'h0040, 16'h0200));
        endcase
    endfunction

    function automatic logic [15:0] pick_coord(logic [15:0] lim);
        case ($urandom_range(0, 9))
            0:       return lim;
            1:       return lim - 16'd1;
            2, 3:    return 16'($urandom);
            default: return (lim == 0) ? 16'($urandom) : 16'($urandom_range(0, lim - 1));
        endcase
    endfunction

    // Mostly finish the image load, then mix scales, fetches, extra loads and no-ops
    function automatic t_in make_word();
        t_in         w;
        int unsigned pick;
        int unsigned total;
        w = make_req(REQ_NOP, $urandom, 16'($urandom), 16'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom));
        total = sb.src_cols() * sb.src_rows();
        pick  = $urandom_range(0, 99);
        if ((sb.loaded < total && pick < 70) || (pick >= 70 && pick < 74)) begin
            w.req_type = REQ_LOAD;
        end else if (pick >= 74 && pick < 84) begin
            w.req_type = REQ_SCALE;
            w.x_scale  = pick_scale();
            w.y_scale  = pick_scale();
        end else if (pick < 97) begin
            w.req_type   = REQ_FETCH;
            w.out_column = pick_coord(sb.cur_w);
            w.out_row    = pick_coord(sb.cur_h);
            // steer clear of entries never loaded
            if (!sb.fetch_safe(w.out_column, w.out_row)) begin
                w.out_column = 16'hFFFF;
                w.out_row    = 16'hFFFF;
            end
        end
        return w;
    endfunction

    initial begin
        sb = new();
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: 3x2 image, edge fields, saturation and every status
        set_source(8'd3, 8'd2);
        send_paced(make_req(REQ_FETCH, '0, '0, '0, 1'b0, 16'd0, 16'd0));
        send_paced(make_req(REQ_NOP, '1, '1, '1, 1'b1, '1, '1));
        send_paced(make_req(REQ_SCALE, '0, 16'h0100, 16'h0100, 1'b1, '0, '0));
        send_paced(make_req(REQ_LOAD, 32'h0000_0000, '0, '0, 1'b0, '0, '0));
        send_paced(make_req(REQ_LOAD, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, '0));
        repeat (4) send_paced(make_req(REQ_LOAD, $urandom, '0, '0, 1'b0, '0, '0));
        send_paced(make_req(REQ_LOAD, 32'hA5A5_A5A5, '0, '0, 1'b0, '0, '0));
        send_paced(make_req(REQ_FETCH, '0, '0, '0, 1'b0, 16'd0, 16'd0));
        send_paced(make_req(REQ_FETCH, '0, '0, '0, 1'b0, 16'd2, 16'd1));
        send_paced(make_req(REQ_FETCH, '0, '0, '0, 1'b0, 16'd3, 16'd0));
        send_paced(make_req(REQ_FETCH, '0, '0, '0, 1'b0, 16'd0, 16'd2));
        send_paced(make_req(REQ_FETCH, '0, '0, '0, 1'b0, 16'hFFFF, 16'hFFFF));
        send_paced(make_req(REQ_SCALE, '0, 16'hFFFF, 16'hFFFF, 1'b0, '0, '0));
        send_paced(make_req(REQ_SCALE, '0, 16'hFFFF, 16'hFFFF, 1'b1, '0, '0));
        send_paced(make_req(REQ_FETCH, '0, '0, '0, 1'b0, 16'hFFFE, 16'hFFFE));
        send_paced(make_req(REQ_SCALE, '0, 16'h0080, 16'h0080, 1'b0, '0, '0));
        send_paced(make_req(REQ_FETCH, '0, '0, '0, 1'b0, 16'd0, 16'd0));
        send_paced(make_req(REQ_SCALE, '0, 16'h0000, 16'h0000, 1'b0, '0, '0));
        send_paced(make_req(REQ_FETCH, '0, '0, '0, 1'b0, 16'd0, 16'd0));
        send_paced(make_req(REQ_SCALE, '0, 16'h0100, 16'h0100, 1'b0, '0, '0));

        // Random phases over a range of source sizes
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_source(8'(phase_w[p]), 8'(phase_h[p]));
            for (int k = 0; k < phase_n[p]; k++) begin
                send_paced(make_word());
                if ($urandom_range(0, 149) == 0) wait_drained();
            end
        end

        // Drain, then let any stray word show up
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("nearest_neighbour_image_scaler verification clean");
        end else begin
            $display("nearest_neighbour_image_scaler verification failed");
        end
        $finish;
    end
endmodule

### files.f
src/nns_pkg.sv
src/nns_ram.sv
src/nns_serial_unit.sv
src/nearest_neighbour_image_scaler.sv
tb/sv/testbench.sv
